// File: sv/tct_pkg.sv
// tct_pkg: types, codes and helper functions of the three-channel interval timer
// no dependencies; used by tct_channel, the top level and the testbench
`default_nettype none

package tct_pkg;

  // channel count: default and the most the port widths allow
  localparam int unsigned NUM_CHANNELS_DEF = 3;
  localparam int unsigned MAX_CHANNELS     = 3;

  // port address of the control word
  localparam logic [2:0] ADDR_CTRL = 3'd3;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_GATE  = 2'd3
  } kind_e;

  // access field of the control word; zero is the latch command
  typedef enum logic [1:0] {
    ACC_LATCH = 2'd0,
    ACC_LSB   = 2'd1,
    ACC_MSB   = 2'd2,
    ACC_WORD  = 2'd3
  } acc_e;

  // operating modes after folding 6 and 7 onto 2 and 3
  localparam logic [2:0] MODE_TC_INT    = 3'd0;
  localparam logic [2:0] MODE_ONESHOT   = 3'd1;
  localparam logic [2:0] MODE_RATE      = 3'd2;
  localparam logic [2:0] MODE_SQUARE    = 3'd3;
  localparam logic [2:0] MODE_SW_STROBE = 3'd4;
  localparam logic [2:0] MODE_HW_STROBE = 3'd5;

  // one decoded transaction as seen by a single channel
  typedef struct packed {
    logic       rd;
    logic       wr;
    logic       ctl;
    logic       tick;
    logic       gate;
    logic [7:0] data;
    logic       gate_level;
  } chan_cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] out_levels;
    logic [2:0] prev_out_levels;
  } result_t;

  function automatic logic [2:0] eff_mode(input logic [2:0] m);
    eff_mode = (m[2] && m[1]) ? {1'b0, m[1:0]} : m;
  endfunction

  // bcd correction after a binary decrement, nibbles low to high
  function automatic logic [15:0] bcd_fix(input logic [15:0] v_in);
    logic [15:0] v;
    v = v_in;
    if ((v & 16'h000F) > 16'h0009) v = v - 16'h0006;
    if ((v & 16'h00F0) > 16'h0090) v = v - 16'h0060;
    if ((v & 16'h0F00) > 16'h0900) v = v - 16'h0600;
    if ((v & 16'hF000) > 16'h9000) v = v - 16'h6000;
    bcd_fix = v;
  endfunction

endpackage

`default_nettype wire

// File: sv/tct_if.sv
// tct_in_if / tct_out_if: valid-ready channels of the interval timer
// depends on nothing but the port widths of the timer
`default_nettype none

interface tct_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] address;
  logic [7:0] write_data;
  logic [1:0] gate_channel;
  logic       gate_level;

  modport source (output valid, kind, address, write_data, gate_channel, gate_level,
                  input ready);
  modport sink   (input valid, kind, address, write_data, gate_channel, gate_level,
                  output ready);
endinterface

interface tct_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [2:0] out_levels;
  logic [2:0] prev_out_levels;

  modport source (output valid, read_data, out_levels, prev_out_levels, input ready);
  modport sink   (input valid, read_data, out_levels, prev_out_levels, output ready);
endinterface

`default_nettype wire

// File: sv/three_channel_interval_timer.sv
// three_channel_interval_timer: top level, input register, decode, result register
// depends on tct_pkg, tct_if.sv and tct_channel
`default_nettype none

// Interval timer with up to three 8254-style counter channels. Every input
// transaction (bus read, bus write, counter tick or gate change) yields exactly one
// result carrying the read byte (0xFF unless a data port was read) and the
// current and previous output levels of all channels. One transaction is taken
// per clock. A transaction waits in the input register until it can advance, and
// its result then waits in the result register until it is taken.
// The per-channel register update between them is what bounds the clock. When
// both registers are full and the result is not taken, the input side stalls.

module three_channel_interval_timer #(
  parameter int unsigned NUM_CHANNELS = tct_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tct_in_if.sink    in_i,
  tct_out_if.source out_o
);

  logic              in_valid_q;
  tct_pkg::kind_e    kind_q;
  logic [2:0]        addr_q;
  logic [7:0]        data_q;
  logic [1:0]        gch_q;
  logic              glv_q;

  logic              out_valid_q;
  tct_pkg::result_t  res_q, res_d;
  logic              bcd_q, bcd_d;

  logic              advance;
  logic              ctl_mode_set;

  tct_pkg::chan_cmd_t cmd       [tct_pkg::MAX_CHANNELS];
  logic [7:0]         rd_ch     [4];
  logic [2:0]         lv, pv;

  assign advance      = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready   = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      kind_q <= tct_pkg::kind_e'(in_i.kind);
      addr_q <= in_i.address;
      data_q <= in_i.write_data;
      gch_q  <= in_i.gate_channel;
      glv_q  <= in_i.gate_level;
    end
  end

  for (genvar c = 0; c < tct_pkg::MAX_CHANNELS; c++) begin : g_chan
    if (c < NUM_CHANNELS) begin : g_on
      always_comb begin
        cmd[c].rd   = advance && kind_q == tct_pkg::KIND_READ && addr_q == 3'(c);
        cmd[c].wr   = advance && kind_q == tct_pkg::KIND_WRITE && addr_q == 3'(c);
        cmd[c].ctl  = advance && kind_q == tct_pkg::KIND_WRITE
                      && addr_q == tct_pkg::ADDR_CTRL && data_q[7:6] == 2'(c);
        cmd[c].tick = advance && kind_q == tct_pkg::KIND_TICK;
        cmd[c].gate = advance && kind_q == tct_pkg::KIND_GATE && gch_q == 2'(c);
        cmd[c].data       = data_q;
        cmd[c].gate_level = glv_q;
      end

      tct_channel u_chan (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .cmd_i     (cmd[c]),
        .bcd_i     (bcd_q),
        .rd_data_o (rd_ch[c]),
        .out_o     (lv[c]),
        .prev_o    (pv[c])
      );
    end else begin : g_off
      assign cmd[c]   = '0;
      assign rd_ch[c] = 8'hFF;
      assign lv[c]    = 1'b0;
      assign pv[c]    = 1'b0;
    end
  end

  assign rd_ch[3] = 8'hFF;

  // mode-set command to a present channel carries the global bcd flag
  assign ctl_mode_set = advance && kind_q == tct_pkg::KIND_WRITE
                        && addr_q == tct_pkg::ADDR_CTRL
                        && 32'(data_q[7:6]) < NUM_CHANNELS
                        && tct_pkg::acc_e'(data_q[5:4]) != tct_pkg::ACC_LATCH;
  assign bcd_d = ctl_mode_set ? data_q[0] : bcd_q;

  always_comb begin
    res_d.read_data       = 8'hFF;
    if (kind_q == tct_pkg::KIND_READ && !addr_q[2]) res_d.read_data = rd_ch[addr_q[1:0]];
    res_d.out_levels      = lv;
    res_d.prev_out_levels = pv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      bcd_q       <= 1'b0;
    end else begin
      bcd_q <= bcd_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.read_data       = res_q.read_data;
  assign out_o.out_levels      = res_q.out_levels;
  assign out_o.prev_out_levels = res_q.prev_out_levels;

  // a transaction leaving the input register always lands in the result register
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not loaded after advance");

  // anything but a read returns the idle byte
  a_nonread_ff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && kind_q != tct_pkg::KIND_READ |=> res_q.read_data == 8'hFF)
    else $error("non-read transaction returned data");

  // with the result register empty the input side never stalls
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty result register");

  // the bcd flag only moves on a mode-set command
  a_bcd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_mode_set |=> $stable(bcd_q))
    else $error("bcd flag changed without a control word");

endmodule

`default_nettype wire

// File: sv/tct_channel.sv
// tct_channel: state and per-transaction update of one counter channel
// depends on tct_pkg
`default_nettype none

module tct_channel (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tct_pkg::chan_cmd_t cmd_i,
  input  wire logic              bcd_i,
  output logic [7:0]             rd_data_o,
  output logic                   out_o,
  output logic                   prev_o
);

  logic [15:0]   reload_q, reload_d;
  logic [15:0]   count_q, count_d;
  logic [15:0]   latched_q, latched_d;
  logic [1:0]    pend_q, pend_d;
  tct_pkg::acc_e acc_q, acc_d;
  logic [2:0]    mode_q, mode_d;
  logic          tog_q, tog_d;
  logic          wait_rl_q, wait_rl_d;
  logic          wait_gt_q, wait_gt_d;
  logic          gate_q, gate_d;
  logic          out_q, out_d;
  logic          prev_q, prev_d;

  logic [2:0]  m;
  logic [15:0] rd_val;
  logic [15:0] dec;
  logic        rise;

  always_comb begin
    reload_d  = reload_q;
    count_d   = count_q;
    latched_d = latched_q;
    pend_d    = pend_q;
    acc_d     = acc_q;
    mode_d    = mode_q;
    tog_d     = tog_q;
    wait_rl_d = wait_rl_q;
    wait_gt_d = wait_gt_q;
    gate_d    = gate_q;
    out_d     = out_q;
    prev_d    = prev_q;
    rd_data_o = 8'hFF;

    m      = tct_pkg::eff_mode(mode_q);
    rd_val = (pend_q != 2'b00) ? latched_q : count_q;
    dec    = count_q - 16'd1;
    if (bcd_i) dec = tct_pkg::bcd_fix(dec);
    rise   = !gate_q && cmd_i.gate_level;

    if (cmd_i.rd) begin
      case (acc_q)
        tct_pkg::ACC_LSB: begin
          rd_data_o = rd_val[7:0];
          pend_d    = pend_q & 2'b10;
        end
        tct_pkg::ACC_MSB: begin
          rd_data_o = rd_val[15:8];
          pend_d    = pend_q & 2'b01;
        end
        tct_pkg::ACC_WORD: begin
          if (tog_q) begin
            rd_data_o = rd_val[15:8];
            pend_d    = pend_q & 2'b01;
          end else begin
            rd_data_o = rd_val[7:0];
            pend_d    = pend_q & 2'b10;
          end
          tog_d = !tog_q;
        end
        default: ;
      endcase
    end

    if (cmd_i.wr) begin
      case (acc_q)
        tct_pkg::ACC_LSB: begin
          reload_d  = {reload_q[15:8], cmd_i.data};
          wait_rl_d = 1'b0;
          tog_d     = 1'b0;
        end
        tct_pkg::ACC_MSB: begin
          reload_d  = {cmd_i.data, reload_q[7:0]};
          wait_rl_d = 1'b0;
          tog_d     = 1'b0;
        end
        tct_pkg::ACC_WORD: begin
          if (tog_q) begin
            reload_d  = {cmd_i.data, reload_q[7:0]};
            wait_rl_d = 1'b0;
          end else begin
            reload_d  = {reload_q[15:8], cmd_i.data};
            wait_rl_d = 1'b1;
          end
          tog_d = !tog_q;
        end
        default: ;
      endcase
      // counting modes without a gate trigger load straight away
      if (!wait_rl_d && (m == tct_pkg::MODE_TC_INT || m == tct_pkg::MODE_SW_STROBE)) begin
        count_d = reload_d;
      end
    end

    if (cmd_i.ctl) begin
      if (tct_pkg::acc_e'(cmd_i.data[5:4]) == tct_pkg::ACC_LATCH) begin
        latched_d = count_q;
        pend_d    = 2'b11;
      end else begin
        acc_d     = tct_pkg::acc_e'(cmd_i.data[5:4]);
        mode_d    = cmd_i.data[3:1];
        out_d     = (cmd_i.data[3:1] != tct_pkg::MODE_TC_INT);
        wait_rl_d = 1'b1;
        wait_gt_d = 1'b0;
        tog_d     = 1'b0;
      end
    end

    if (cmd_i.tick && !wait_rl_q && !wait_gt_q) begin
      count_d = dec;
      if (dec == 16'd0) begin
        case (m)
          tct_pkg::MODE_TC_INT, tct_pkg::MODE_ONESHOT: begin
            prev_d = out_q;
            out_d  = 1'b1;
          end
          tct_pkg::MODE_RATE: begin
            prev_d  = 1'b0;
            out_d   = 1'b1;
            count_d = reload_q;
          end
          tct_pkg::MODE_SQUARE: begin
            prev_d  = out_q;
            out_d   = !out_q;
            count_d = reload_q;
          end
          tct_pkg::MODE_SW_STROBE: begin
            prev_d = 1'b0;
            out_d  = 1'b1;
          end
          default: out_d = 1'b0;
        endcase
      end
    end

    if (cmd_i.gate) begin
      case (m)
        tct_pkg::MODE_ONESHOT: begin
          if (!wait_rl_q && rise) begin
            prev_d  = out_q;
            out_d   = 1'b0;
            count_d = reload_q;
          end
        end
        tct_pkg::MODE_RATE: begin
          if (!cmd_i.gate_level) begin
            wait_gt_d = 1'b1;
            prev_d    = out_q;
            out_d     = 1'b1;
          end else if (rise) begin
            count_d   = reload_q;
            wait_gt_d = 1'b0;
          end
        end
        tct_pkg::MODE_SQUARE: begin
          if (!cmd_i.gate_level) begin
            wait_gt_d = 1'b1;
          end else if (rise) begin
            count_d   = reload_q;
            wait_gt_d = 1'b0;
          end
        end
        tct_pkg::MODE_SW_STROBE: begin
          if (!cmd_i.gate_level) wait_rl_d = 1'b1;
        end
        tct_pkg::MODE_HW_STROBE: begin
          if (rise) begin
            count_d   = reload_q;
            wait_gt_d = 1'b0;
          end
        end
        default: ;
      endcase
      gate_d = cmd_i.gate_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q  <= '0;
      count_q   <= '0;
      latched_q <= '0;
      pend_q    <= '0;
      acc_q     <= tct_pkg::ACC_LATCH;
      mode_q    <= '0;
      tog_q     <= 1'b0;
      wait_rl_q <= 1'b0;
      wait_gt_q <= 1'b1;
      gate_q    <= 1'b1;
      out_q     <= 1'b0;
      prev_q    <= 1'b0;
    end else begin
      reload_q  <= reload_d;
      count_q   <= count_d;
      latched_q <= latched_d;
      pend_q    <= pend_d;
      acc_q     <= acc_d;
      mode_q    <= mode_d;
      tog_q     <= tog_d;
      wait_rl_q <= wait_rl_d;
      wait_gt_q <= wait_gt_d;
      gate_q    <= gate_d;
      out_q     <= out_d;
      prev_q    <= prev_d;
    end
  end

  // levels as they stand after this transaction
  assign out_o  = out_d;
  assign prev_o = prev_d;

endmodule

`default_nettype wire

// File: tb/sv/interval_timer_checker.sv
// interval_timer_checker: watches both channels of the interval timer, predicts
// every result from its own model of the three counters and compares them
// depends on tct_pkg and the channel interfaces in tct_if.sv
`timescale 1ns / 1ps

module interval_timer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  tct_in_if           cmd_if_i,
  tct_out_if          res_if_i,
  output int unsigned results_due_o,
  output int unsigned mismatches_o
);
  import tct_pkg::*;

  localparam int CHANNELS = 3;

  logic [15:0] reload_val [CHANNELS];
  logic [15:0] cnt        [CHANNELS];
  logic [15:0] latched    [CHANNELS];
  logic [1:0]  latch_pend [CHANNELS];
  logic [1:0]  acc        [CHANNELS];
  logic [2:0]  opm        [CHANNELS];
  logic        toggle     [CHANNELS];
  logic        wait_load  [CHANNELS];
  logic        wait_gt    [CHANNELS];
  logic        gate_lvl   [CHANNELS];
  logic        out_lvl    [CHANNELS];
  logic        prev_out   [CHANNELS];
  logic        bcd;

  result_t     timer_results_due [$];
  int unsigned mismatch_count;

  function automatic void clear_timer_state();
    for (int c = 0; c < CHANNELS; c++) begin
      reload_val[c] = '0;
      cnt[c]        = '0;
      latched[c]    = '0;
      latch_pend[c] = '0;
      acc[c]        = ACC_LATCH;
      opm[c]        = MODE_TC_INT;
      toggle[c]     = 1'b0;
      wait_load[c]  = 1'b0;
      wait_gt[c]    = 1'b1;
      gate_lvl[c]   = 1'b1;
      out_lvl[c]    = 1'b0;
      prev_out[c]   = 1'b0;
    end
    bcd = 1'b0;
  endfunction

  // modes 6 and 7 run as 2 and 3
  function automatic logic [2:0] folded_mode(input int c);
    return (opm[c] >= 3'd6) ? opm[c] - 3'd4 : opm[c];
  endfunction

  function automatic logic [7:0] read_port(input int c);
    logic [15:0] v;
    logic [7:0]  r;
    v = (latch_pend[c] != 2'b00) ? latched[c] : cnt[c];
    r = 8'hFF;
    case (acc[c])
      ACC_LSB: begin
        r = v[7:0];
        latch_pend[c][0] = 1'b0;
      end
      ACC_MSB: begin
        r = v[15:8];
        latch_pend[c][1] = 1'b0;
      end
      ACC_WORD: begin
        if (toggle[c]) begin
          r = v[15:8];
          latch_pend[c][1] = 1'b0;
        end else begin
          r = v[7:0];
          latch_pend[c][0] = 1'b0;
        end
        toggle[c] = ~toggle[c];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void write_port(input int c, input logic [7:0] d);
    case (acc[c])
      ACC_LSB: begin
        reload_val[c][7:0] = d;
        wait_load[c] = 1'b0;
        toggle[c]    = 1'b0;
      end
      ACC_MSB: begin
        reload_val[c][15:8] = d;
        wait_load[c] = 1'b0;
        toggle[c]    = 1'b0;
      end
      ACC_WORD: begin
        if (toggle[c]) begin
          reload_val[c][15:8] = d;
          wait_load[c] = 1'b0;
        end else begin
          reload_val[c][7:0] = d;
          wait_load[c] = 1'b1;
        end
        toggle[c] = ~toggle[c];
      end
      default: ;
    endcase
    // latch-zero access still runs the load step
    if (!wait_load[c] && (folded_mode(c) == MODE_TC_INT || folded_mode(c) == MODE_SW_STROBE))
      cnt[c] = reload_val[c];
  endfunction

  function automatic void write_control(input logic [7:0] d);
    int c;
    c = d[7:6];
    if (c >= CHANNELS) return;
    if (d[5:4] == ACC_LATCH) begin
      latched[c]    = cnt[c];
      latch_pend[c] = 2'b11;
      return;
    end
    acc[c]       = d[5:4];
    opm[c]       = d[3:1];
    out_lvl[c]   = (d[3:1] != MODE_TC_INT);
    wait_load[c] = 1'b1;
    wait_gt[c]   = 1'b0;
    toggle[c]    = 1'b0;
    bcd          = d[0];
  endfunction

  function automatic void count_down(input int c);
    logic [15:0] v;
    if (wait_load[c] || wait_gt[c]) return;
    v = cnt[c] - 16'd1;
    if (bcd) begin
      // pull each nibble above nine back into decimal range, low nibble first
      for (int n = 0; n < 4; n++)
        if (((v >> (4 * n)) & 16'h000F) > 16'd9) v = v - (16'd6 << (4 * n));
    end
    cnt[c] = v;
    if (v != 16'd0) return;
    case (folded_mode(c))
      MODE_TC_INT, MODE_ONESHOT: begin
        prev_out[c] = out_lvl[c];
        out_lvl[c]  = 1'b1;
      end
      MODE_RATE: begin
        prev_out[c] = 1'b0;
        out_lvl[c]  = 1'b1;
        cnt[c]      = reload_val[c];
      end
      MODE_SQUARE: begin
        prev_out[c] = out_lvl[c];
        out_lvl[c]  = ~out_lvl[c];
        cnt[c]      = reload_val[c];
      end
      MODE_SW_STROBE: begin
        prev_out[c] = 1'b0;
        out_lvl[c]  = 1'b1;
      end
      default: out_lvl[c] = 1'b0;
    endcase
  endfunction

  function automatic void change_gate(input int c, input logic g);
    logic rise;
    rise = !gate_lvl[c] && g;
    case (folded_mode(c))
      MODE_ONESHOT: begin
        if (!wait_load[c] && rise) begin
          prev_out[c] = out_lvl[c];
          out_lvl[c]  = 1'b0;
          cnt[c]      = reload_val[c];
        end
      end
      MODE_RATE: begin
        if (!g) begin
          wait_gt[c]  = 1'b1;
          prev_out[c] = out_lvl[c];
          out_lvl[c]  = 1'b1;
        end else if (rise) begin
          cnt[c]     = reload_val[c];
          wait_gt[c] = 1'b0;
        end
      end
      MODE_SQUARE: begin
        if (!g) begin
          wait_gt[c] = 1'b1;
        end else if (rise) begin
          cnt[c]     = reload_val[c];
          wait_gt[c] = 1'b0;
        end
      end
      MODE_SW_STROBE: begin
        if (!g) wait_load[c] = 1'b1;
      end
      MODE_HW_STROBE: begin
        if (rise) begin
          cnt[c]     = reload_val[c];
          wait_gt[c] = 1'b0;
        end
      end
      default: ;
    endcase
    gate_lvl[c] = g;
  endfunction

  function automatic result_t predict_timer_result(input logic [1:0] kind,
                                                   input logic [2:0] addr,
                                                   input logic [7:0] data,
                                                   input logic [1:0] gch,
                                                   input logic       glv);
    result_t r;
    r.read_data = 8'hFF;
    case (kind)
      KIND_READ: begin
        if (addr < CHANNELS) r.read_data = read_port(addr);
      end
      KIND_WRITE: begin
        if (addr < CHANNELS) write_port(addr, data);
        else if (addr == ADDR_CTRL) write_control(data);
      end
      KIND_TICK: begin
        for (int c = 0; c < CHANNELS; c++) count_down(c);
      end
      default: begin
        if (gch < CHANNELS) change_gate(gch, glv);
      end
    endcase
    for (int c = 0; c < CHANNELS; c++) begin
      r.out_levels[c]      = out_lvl[c];
      r.prev_out_levels[c] = prev_out[c];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      clear_timer_state();
      timer_results_due.delete();
      mismatch_count = 0;
      results_due_o <= 0;
      mismatches_o  <= 0;
    end else begin
      if (cmd_if_i.valid && cmd_if_i.ready)
        timer_results_due.push_back(predict_timer_result(cmd_if_i.kind, cmd_if_i.address,
          cmd_if_i.write_data, cmd_if_i.gate_channel, cmd_if_i.gate_level));
      if (res_if_i.valid && res_if_i.ready) begin
        if (timer_results_due.size() == 0) begin
          $error("unexpected result: read_data %02h out_levels %03b prev_out_levels %03b",
                 res_if_i.read_data, res_if_i.out_levels, res_if_i.prev_out_levels);
          mismatch_count++;
        end else begin
          want = timer_results_due.pop_front();
          if (res_if_i.read_data !== want.read_data) begin
            $error("read_data: expected %02h, got %02h", want.read_data, res_if_i.read_data);
            mismatch_count++;
          end
          if (res_if_i.out_levels !== want.out_levels) begin
            $error("out_levels: expected %03b, got %03b",
                   want.out_levels, res_if_i.out_levels);
            mismatch_count++;
          end
          if (res_if_i.prev_out_levels !== want.prev_out_levels) begin
            $error("prev_out_levels: expected %03b, got %03b",
                   want.prev_out_levels, res_if_i.prev_out_levels);
            mismatch_count++;
          end
        end
      end
      results_due_o <= timer_results_due.size();
      mismatches_o  <= mismatch_count;
    end
  end

endmodule

// File: tb/sv/three_channel_interval_timer_tb.sv
// three_channel_interval_timer_tb: drives bus, tick and gate transactions into the
// timer and paces the result side; depends on tct_pkg, tct_if.sv, the timer and
// interval_timer_checker, which does all the checking
`timescale 1ns / 1ps

module three_channel_interval_timer_tb;
  import tct_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [2:0]  ADDR_UNUSED_LO  = 3'd4;
  localparam logic [2:0]  ADDR_UNUSED_HI  = 3'd7;
  localparam logic [1:0]  CH_READBACK     = 2'd3;
  localparam logic [1:0]  GATE_NO_CHANNEL = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  int unsigned results_due;
  int unsigned mismatches;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  logic        hold_go;
  int unsigned useful_items;
  int unsigned cycles;

  tct_in_if  in_if ();
  tct_out_if out_if ();

  three_channel_interval_timer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  interval_timer_checker result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_if_i      (in_if),
    .res_if_i      (out_if),
    .results_due_o (results_due),
    .mismatches_o  (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random back-pressure plus one long hold-off
  initial begin
    int unsigned hold_left;
    logic        hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [7:0] ctrl_word(input logic [1:0] ch, input logic [1:0] acc,
                                           input logic [2:0] mode, input logic bcd);
    return {ch, acc, mode, bcd};
  endfunction

  task automatic set_idling(input int unsigned tx, input int unsigned rx);
    tx_idle_pct = tx;
    rx_idle_pct <= rx;
  endtask

  // valid stays high after a transaction; only an idle gap lowers it
  task automatic send_item(input kind_e k, input logic [2:0] a, input logic [7:0] d,
                           input logic [1:0] gc, input logic gl);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.kind         <= k;
    in_if.address      <= a;
    in_if.write_data   <= d;
    in_if.gate_channel <= gc;
    in_if.gate_level   <= gl;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (!((k == KIND_READ || k == KIND_WRITE) && a >= ADDR_UNUSED_LO) &&
        !(k == KIND_GATE && gc == GATE_NO_CHANNEL))
      useful_items++;
  endtask

  // unused fields carry random bits so every input bit toggles
  task automatic bus_read(input logic [2:0] a);
    send_item(KIND_READ, a, 8'($urandom()), 2'($urandom()), 1'($urandom()));
  endtask

  task automatic bus_write(input logic [2:0] a, input logic [7:0] d);
    send_item(KIND_WRITE, a, d, 2'($urandom()), 1'($urandom()));
  endtask

  task automatic tick();
    send_item(KIND_TICK, 3'($urandom()), 8'($urandom()), 2'($urandom()), 1'($urandom()));
  endtask

  task automatic gate(input logic [1:0] ch, input logic lvl);
    send_item(KIND_GATE, 3'($urandom()), 8'($urandom()), ch, lvl);
  endtask

  task automatic random_item();
    send_item(kind_e'($urandom_range(3)), 3'($urandom()), 8'($urandom()),
              2'($urandom()), 1'($urandom()));
  endtask

  // program one channel, load a mostly short count, then run it with ticks, gate
  // changes, reads, latches, data writes and random items
  task automatic exercise_channel(input logic [1:0] ch);
    logic [2:0]  mode;
    logic [1:0]  acc;
    logic        bcd;
    logic [15:0] reload;
    int unsigned steps;
    int unsigned pick;
    mode = 3'($urandom_range(7));
    acc  = 2'($urandom_range(ACC_WORD, ACC_LSB));
    bcd  = ($urandom_range(3) == 0);
    case ($urandom_range(9))
      0:       reload = 16'($urandom());
      1:       reload = 16'd0;
      default: reload = 16'($urandom_range(12, 1));
    endcase
    bus_write(ADDR_CTRL, ctrl_word(ch, acc, mode, bcd));
    case (acc)
      ACC_LSB: bus_write({1'b0, ch}, reload[7:0]);
      ACC_MSB: bus_write({1'b0, ch}, reload[15:8]);
      default: begin
        bus_write({1'b0, ch}, reload[7:0]);
        bus_write({1'b0, ch}, reload[15:8]);
      end
    endcase
    steps = $urandom_range(24, 4);
    repeat (steps) begin
      pick = $urandom_range(99);
      if (pick < 48)      tick();
      else if (pick < 62) gate(ch, 1'($urandom()));
      else if (pick < 74) bus_read({1'b0, ch});
      else if (pick < 82) bus_write(ADDR_CTRL, ctrl_word(ch, ACC_LATCH,
                                    3'($urandom()), 1'($urandom())));
      else if (pick < 88) bus_read(3'($urandom_range(2)));
      else if (pick < 93) bus_write({1'b0, ch}, 8'($urandom_range(15)));
      else                random_item();
    end
  endtask

  task automatic random_chunk();
    if ($urandom_range(3) != 0) exercise_channel(2'($urandom_range(2)));
    else repeat ($urandom_range(3, 1)) random_item();
  endtask

  initial begin
    cycles       = 0;
    useful_items = 0;
    tx_idle_pct  = 25;
    rx_idle_pct  = 51;
    hold_go      = 1'b0;
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.kind         <= KIND_READ;
    in_if.address      <= '0;
    in_if.write_data   <= '0;
    in_if.gate_channel <= '0;
    in_if.gate_level   <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset state, one-off count, square wave in bcd, latch,
    // hardware strobe, read-back and the unused ports
    bus_read(3'd0);
    tick();
    bus_write(ADDR_CTRL, ctrl_word(2'd0, ACC_LSB, MODE_TC_INT, 1'b0));
    bus_write(3'd0, 8'h03);
    repeat (3) tick();
    bus_read(3'd0);
    bus_write(ADDR_CTRL, ctrl_word(2'd1, ACC_WORD, 3'd7, 1'b1));
    bus_write(3'd1, 8'h02);
    bus_write(3'd1, 8'h00);
    gate(2'd1, 1'b0);
    gate(2'd1, 1'b1);
    repeat (2) tick();
    bus_write(ADDR_CTRL, ctrl_word(2'd0, ACC_LATCH, MODE_TC_INT, 1'b0));
    tick();
    bus_read(3'd0);
    bus_write(ADDR_CTRL, ctrl_word(2'd2, ACC_MSB, MODE_HW_STROBE, 1'b0));
    bus_write(3'd2, 8'hFF);
    gate(2'd2, 1'b0);
    gate(2'd2, 1'b1);
    bus_write(ADDR_CTRL, ctrl_word(CH_READBACK, ACC_WORD, 3'd7, 1'b1));
    bus_write(ADDR_UNUSED_HI, 8'hFF);
    bus_read(ADDR_CTRL);
    bus_read(ADDR_UNUSED_LO);
    gate(GATE_NO_CHANNEL, 1'b0);

    while (useful_items < 220) random_chunk();
    set_idling(51, 25);
    while (useful_items < 400) random_chunk();
    // no idling; the result side holds off for a while so the timer backs up
    set_idling(0, 0);
    hold_go <= 1'b1;
    while (useful_items < 575) random_chunk();

    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (results_due != 0);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && results_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
